// ----- rtl/core/dda_pkg.sv -----
package dda_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned BaseW   = 13;
  localparam int unsigned DiffW   = 14;
  localparam int unsigned TotalW  = 16;
  localparam int unsigned ProdW   = 21;
  localparam int unsigned DensW   = 15;
  localparam int unsigned LimitW  = 14;
  localparam int unsigned LevelW  = 2;
  localparam int unsigned CountW  = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned WinLen  = 5;

  localparam logic [CountW-1:0] CalCount  = CountW'(5);
  localparam logic [CountW-1:0] FullCount = CountW'(10);

  localparam logic [LimitW-1:0] CleanReset = LimitW'(300);
  localparam logic [LimitW-1:0] FairReset  = LimitW'(800);
  localparam logic [LimitW-1:0] PoorReset  = LimitW'(1500);

  typedef enum logic [CfgIdxW-1:0] {
    CfgClean = 2'd0,
    CfgFair  = 2'd1,
    CfgPoor  = 2'd2
  } cfg_idx_e;

  typedef enum logic [LevelW-1:0] {
    LevelClean = 2'd0,
    LevelFair  = 2'd1,
    LevelPoor  = 2'd2,
    LevelBad   = 2'd3
  } dust_level_e;

  typedef struct packed {
    logic [LimitW-1:0] clean;
    logic [LimitW-1:0] fair;
    logic [LimitW-1:0] poor;
  } limits_t;

endpackage

// ----- rtl/core/dust_density_averager_core.sv -----
// Dust density averager. Takes one 10-bit ADC word per cycle and returns one
// result word per input word, in the cycle after acceptance; full throughput of
// one word per clock as long as the output side takes results. The first five
// words after reset build the baseline sum and yield density 0, level clean,
// ready 0. Each later word adds 5*sample minus the baseline to a five-entry
// window with a running sum S; once the window holds five differences (tenth
// word on), ready_res is 1 and density_tenths = floor(S*25/64) in tenths of
// ug/m3. dust_level classes the density against the clean, fair and poor
// limits (indexes 0, 1, 2 of the write port), checked in that order. Write
// the limits only while no word is in flight.
module dust_density_averager_core import dda_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [SampleW-1:0]       adc_sample_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DensW-1:0]  density_tenths_o,
  output logic [LevelW-1:0]        dust_level_o,
  output logic                     ready_res_o,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [LimitW-1:0]        cfg_wdata_i
);

  limits_t                  limits_q;
  logic [BaseW-1:0]         base_q, base_d;
  logic signed [DiffW-1:0]  win_q [WinLen];
  logic signed [TotalW-1:0] total_q, total_d;
  logic [CountW-1:0]        count_q, count_d;
  logic                     out_valid_q;
  logic signed [TotalW-1:0] out_total_q;
  logic                     out_ready_q;

  logic                     accept;
  logic                     calib;
  logic [BaseW-1:0]         sample_x5;
  logic signed [DiffW-1:0]  diff;
  logic                     ready_d;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign calib      = count_q < CalCount;

  assign sample_x5 = (BaseW'(adc_sample_i) << 2) + BaseW'(adc_sample_i);
  assign diff      = $signed({1'b0, sample_x5}) - $signed({1'b0, base_q});

  always_comb begin
    base_d  = base_q;
    total_d = total_q;
    count_d = count_q;
    if (calib) begin
      base_d  = base_q + BaseW'(adc_sample_i);
      count_d = count_q + 1'b1;
    end else begin
      total_d = total_q - TotalW'(win_q[0]) + TotalW'(diff);
      if (count_q < FullCount) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  assign ready_d = ~calib & (count_d >= FullCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q <= '{clean: CleanReset, fair: FairReset, poor: PoorReset};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgClean: limits_q.clean <= cfg_wdata_i;
        CfgFair:  limits_q.fair  <= cfg_wdata_i;
        CfgPoor:  limits_q.poor  <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      total_q <= '0;
      count_q <= '0;
      for (int i = 0; i < WinLen; i++) begin
        win_q[i] <= '0;
      end
    end else if (accept) begin
      base_q  <= base_d;
      total_q <= total_d;
      count_q <= count_d;
      if (!calib) begin
        for (int i = 0; i < WinLen - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[WinLen-1] <= diff;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_total_q <= total_d;
      out_ready_q <= ready_d;
    end
  end

  dda_scale u_scale (
    .total_i   (out_total_q),
    .ready_i   (out_ready_q),
    .limits_i  (limits_q),
    .density_o (density_tenths_o),
    .level_o   (dust_level_o)
  );

  assign out_valid_o = out_valid_q;
  assign ready_res_o = out_ready_q;

endmodule

// ----- rtl/core/dda_scale.sv -----
module dda_scale import dda_pkg::*; (
  input  logic signed [TotalW-1:0] total_i,
  input  logic                     ready_i,
  input  limits_t                  limits_i,
  output logic signed [DensW-1:0]  density_o,
  output logic [LevelW-1:0]        level_o
);

  logic signed [ProdW-1:0]  total_ext;
  logic signed [ProdW-1:0]  prod;
  logic signed [ProdW-1:0]  shifted;
  logic signed [DensW-1:0]  density;
  logic signed [DensW:0]    dens_cmp;
  logic signed [DensW:0]    clean_cmp;
  logic signed [DensW:0]    fair_cmp;
  logic signed [DensW:0]    poor_cmp;
  dust_level_e              level;

  // total * 25, then floor divide by 64
  assign total_ext = ProdW'(total_i);
  assign prod      = (total_ext <<< 4) + (total_ext <<< 3) + total_ext;
  assign shifted   = prod >>> 6;
  assign density   = ready_i ? shifted[DensW-1:0] : '0;

  assign dens_cmp  = {density[DensW-1], density};
  assign clean_cmp = $signed({2'b00, limits_i.clean});
  assign fair_cmp  = $signed({2'b00, limits_i.fair});
  assign poor_cmp  = $signed({2'b00, limits_i.poor});

  always_comb begin
    if (dens_cmp <= clean_cmp) begin
      level = LevelClean;
    end else if (dens_cmp <= fair_cmp) begin
      level = LevelFair;
    end else if (dens_cmp <= poor_cmp) begin
      level = LevelPoor;
    end else begin
      level = LevelBad;
    end
  end

  assign density_o = density;
  assign level_o   = level;

endmodule

// ----- rtl/core/dda_checker.sv -----
module dda_checker import dda_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DensW-1:0]  density_tenths_o,
  input logic [LevelW-1:0]        dust_level_o,
  input logic                     ready_res_o
);

  logic seen_ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_ready_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && ready_res_o) begin
      seen_ready_q <= 1'b1;
    end
  end

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(density_tenths_o)
      && $stable(dust_level_o) && $stable(ready_res_o))
    else $error("stalled result word changed");

  // a new result word needs an accepted input word
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o && out_stall_i)
      |-> $past(in_valid_i && !in_stall_o))
    else $error("result word without input word");

  // not ready means density zero and level clean
  a_not_ready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ready_res_o
      |-> density_tenths_o == '0 && dust_level_o == LevelClean)
    else $error("density reported before window full");

  // once ready, stays ready
  a_ready_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_ready_q |-> ready_res_o)
    else $error("ready dropped after being reported");

endmodule

bind dust_density_averager_core dda_checker u_dda_checker (.*);

// ----- bench/testbench.sv -----
module testbench;
  import dda_pkg::*;

  localparam int Rows = 25;
  localparam int Phases = 9;
  localparam int PhaseItems = 150;
  localparam int IdleLimit = 1000;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef struct packed {
    logic signed [DensW-1:0] dens;
    dust_level_e             level;
    logic                    ready;
  } reading_t;

  typedef struct {
    logic [SampleW-1:0]      sample;
    bit                      typed;
    logic signed [DensW-1:0] dens;
    dust_level_e             level;
    logic                    ready;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [SampleW-1:0] adc_sample;
  logic out_valid;
  logic out_stall;
  logic signed [DensW-1:0] density_tenths;
  logic [LevelW-1:0] dust_level;
  logic ready_res;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [LimitW-1:0] cfg_wdata;

  // predictor state
  logic [BaseW-1:0] base_sum;
  logic signed [DiffW-1:0] diff_win [WinLen];
  logic signed [TotalW-1:0] diff_total;
  logic [CountW-1:0] seen_cnt;
  logic [LimitW-1:0] clean_lim;
  logic [LimitW-1:0] fair_lim;
  logic [LimitW-1:0] poor_lim;

  reading_t pending_readings [$];
  int mismatches = 0;
  int idle_cycles = 0;
  int in_gap_max = 10;
  int out_gap_max = 10;

  // calibration rows first, then extremes and single bits
  stim_row_t dir_rows [Rows] = '{
    '{10'd1023, 1'b1, 15'sd0, LevelClean, 1'b0},
    '{10'd0,    1'b1, 15'sd0, LevelClean, 1'b0},
    '{10'd1023, 1'b1, 15'sd0, LevelClean, 1'b0},
    '{10'd0,    1'b1, 15'sd0, LevelClean, 1'b0},
    '{10'd512,  1'b1, 15'sd0, LevelClean, 1'b0},
    '{10'd1023, 1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd1023, 1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd1023, 1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd1023, 1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd1023, 1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd0,    1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd0,    1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd0,    1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd0,    1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd0,    1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd1,    1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd2,    1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd4,    1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd8,    1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd16,   1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd32,   1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd64,   1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd128,  1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd256,  1'b0, 15'sd0, LevelClean, 1'b0},
    '{10'd512,  1'b0, 15'sd0, LevelClean, 1'b0}
  };

  dust_density_averager_core i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .adc_sample_i     (adc_sample),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .density_tenths_o (density_tenths),
    .dust_level_o     (dust_level),
    .ready_res_o      (ready_res),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic reading_t average_dust(logic [SampleW-1:0] raw);
    reading_t r;
    int diff;
    int dens;
    dens = 0;
    r.ready = 1'b0;
    if (seen_cnt < CalCount) begin
      base_sum = base_sum + BaseW'(raw);
      seen_cnt = seen_cnt + 1'b1;
    end else begin
      diff = 5 * int'(raw) - int'(base_sum);
      diff_total = TotalW'(int'(diff_total) - int'(diff_win[0]) + diff);
      for (int i = 0; i < WinLen - 1; i++) begin
        diff_win[i] = diff_win[i + 1];
      end
      diff_win[WinLen - 1] = DiffW'(diff);
      if (seen_cnt < FullCount) begin
        seen_cnt = seen_cnt + 1'b1;
      end
      if (seen_cnt >= FullCount) begin
        r.ready = 1'b1;
        dens = (int'(diff_total) * 25) >>> 6;
      end
    end
    r.dens = DensW'(dens);
    if (dens <= int'(clean_lim)) begin
      r.level = LevelClean;
    end else if (dens <= int'(fair_lim)) begin
      r.level = LevelFair;
    end else if (dens <= int'(poor_lim)) begin
      r.level = LevelPoor;
    end else begin
      r.level = LevelBad;
    end
    return r;
  endfunction

  task automatic send_sample(logic [SampleW-1:0] s, bit typed, reading_t fixed);
    int gap;
    reading_t guess;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    adc_sample <= s;
    do @(posedge clk); while (in_stall);
    guess = average_dust(s);
    pending_readings.push_back(typed ? fixed : guess);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // a write to the unused index must leave all limits alone
  task automatic set_limits(input logic [LimitW-1:0] c, input logic [LimitW-1:0] f,
                            input logic [LimitW-1:0] p);
    cfg_we <= 1'b1;
    cfg_idx <= CfgClean;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_idx <= CfgFair;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_idx <= CfgPoor;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_idx <= CfgSpare;
    cfg_wdata <= LimitW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    clean_lim = c;
    fair_lim = f;
    poor_lim = p;
  endtask

  initial begin : stimulus
    reading_t fixed;
    int base_mode;
    int run_left;
    logic [SampleW-1:0] run_val;
    logic [LimitW-1:0] lo;
    logic [LimitW-1:0] mid;
    logic [LimitW-1:0] hi;

    in_valid = 1'b0;
    adc_sample = '0;
    cfg_we = 1'b0;
    cfg_idx = CfgClean;
    cfg_wdata = '0;
    rst_n = 1'b0;
    base_sum = '0;
    diff_total = '0;
    seen_cnt = '0;
    for (int i = 0; i < WinLen; i++) begin
      diff_win[i] = '0;
    end
    clean_lim = CleanReset;
    fair_lim = FairReset;
    poor_lim = PoorReset;
    run_left = 0;
    run_val = '0;

    // baseline decides which end of the density range can be reached
    base_mode = $urandom_range(0, 3);
    for (int r = 0; r < 5; r++) begin
      case (base_mode)
        1: dir_rows[r].sample = '0;
        2: dir_rows[r].sample = '1;
        3: dir_rows[r].sample = SampleW'($urandom_range(0, 1023));
        default: ;
      endcase
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < Rows; r++) begin
      fixed.dens = dir_rows[r].dens;
      fixed.level = dir_rows[r].level;
      fixed.ready = dir_rows[r].ready;
      send_sample(dir_rows[r].sample, dir_rows[r].typed, fixed);
    end
    drain();

    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        1: set_limits('0, '0, '0);
        2: set_limits('1, '1, '1);
        3: set_limits(14'd5000, 14'd100, 14'd9990);
        4: set_limits(14'd9990, 14'd9990, 14'd9990);
        7: set_limits(LimitW'($urandom), LimitW'($urandom), LimitW'($urandom));
        5, 6, 8: begin
          lo = LimitW'($urandom_range(0, 3000));
          mid = lo + LimitW'($urandom_range(0, 3000));
          hi = mid + LimitW'($urandom_range(0, 3990));
          set_limits(lo, mid, hi);
        end
        default: ;
      endcase
      in_gap_max = (ph % 3 == 1) ? 0 : 10;
      out_gap_max = in_gap_max;

      for (int k = 0; k < PhaseItems; k++) begin
        if (run_left == 0) begin
          if ($urandom_range(0, 9) < 6) begin
            run_left = $urandom_range(5, 12);
            case ($urandom_range(0, 2))
              0: run_val = '0;
              1: run_val = '1;
              default: run_val = SampleW'($urandom_range(0, 1023));
            endcase
          end else begin
            run_left = 1;
            run_val = SampleW'($urandom_range(0, 1023));
          end
        end
        run_left--;
        send_sample(run_val, 1'b0, '0);
        if ($urandom_range(0, 39) == 0) begin
          drain();
        end
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : result_side
    int hold;
    reading_t want;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_readings.size() == 0) begin
          mismatches++;
          $display("%0t: word with nothing expected, got density %0d level %0d ready %0d",
                   $time, density_tenths, dust_level, ready_res);
        end else begin
          want = pending_readings.pop_front();
          if (density_tenths !== want.dens) begin
            mismatches++;
            $display("%0t: density_tenths expected %0d got %0d",
                     $time, want.dens, density_tenths);
          end
          if (dust_level !== want.level) begin
            mismatches++;
            $display("%0t: dust_level expected %0d got %0d", $time, want.level, dust_level);
          end
          if (ready_res !== want.ready) begin
            mismatches++;
            $display("%0t: ready_res expected %0d got %0d", $time, want.ready, ready_res);
          end
        end
        hold = $urandom_range(0, out_gap_max);
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold > 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
